### hdl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and codes of the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_FULL    = 2'd1;
	localparam logic [1:0] STATUS_REFUSED = 2'd2;

	// One process table entry as held in the entry memory.
	typedef struct packed {
		logic [7:0]  pid;
		logic [15:0] arrival;
		logic [15:0] remaining;
		logic [7:0]  prio;
	} entry_t;

	// Staged result of one transaction.
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] now_time;
		logic        running_valid;
		logic [7:0]  running_pid;
		logic        finished_valid;
		logic [7:0]  finished_pid;
		logic        segment_valid;
		logic [15:0] segment_start;
		logic [15:0] segment_end;
		logic [7:0]  segment_pid;
		logic        all_done;
	} result_t;

	// Control from the sequencer to the selection unit.
	typedef struct packed {
		logic clear;
		logic take;
	} scan_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_TICK_RD,
		ST_UPDATE,
		ST_SCAN,
		ST_FINISH,
		ST_EMIT
	} state_t;

endpackage

### hdl/pps_in_if.sv
// ----------------------------------------------------------------------------
// pps_in_if
// Input channel: load or tick transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pps_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [7:0]  process_id;
	logic [15:0] arrival_time;
	logic [15:0] burst_time;
	logic [7:0]  priority_level;

	modport source (
		output valid, func, process_id, arrival_time, burst_time, priority_level,
		input  ready
	);
	modport sink (
		input  valid, func, process_id, arrival_time, burst_time, priority_level,
		output ready
	);
endinterface

### hdl/pps_out_if.sv
// ----------------------------------------------------------------------------
// pps_out_if
// Result channel: one result per accepted input transaction.
// ----------------------------------------------------------------------------
interface pps_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] now_time;
	logic        running_valid;
	logic [7:0]  running_pid;
	logic        finished_valid;
	logic [7:0]  finished_pid;
	logic        segment_valid;
	logic [15:0] segment_start;
	logic [15:0] segment_end;
	logic [7:0]  segment_pid;
	logic        all_done;

	modport source (
		output valid, status, now_time, running_valid, running_pid, finished_valid,
		       finished_pid, segment_valid, segment_start, segment_end, segment_pid,
		       all_done,
		input  ready
	);
	modport sink (
		input  valid, status, now_time, running_valid, running_pid, finished_valid,
		       finished_pid, segment_valid, segment_start, segment_end, segment_pid,
		       all_done,
		output ready
	);
endinterface

### hdl/pps_entry_mem.sv
// ----------------------------------------------------------------------------
// pps_entry_mem
// Process table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pps_entry_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  pps_pkg::entry_t  wdata,
	input  logic [AW-1:0]    raddr,
	output pps_pkg::entry_t  rdata
);

	pps_pkg::entry_t mem_q [DEPTH];
	pps_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/pps_select.sv
// ----------------------------------------------------------------------------
// pps_select
// Running best-candidate tracker fed one table entry per cycle during a scan.
// ----------------------------------------------------------------------------
module pps_select #(
	parameter int IDX_W = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pps_pkg::scan_ctl_t  ctl,
	input  logic [IDX_W-1:0]    idx,
	input  pps_pkg::entry_t     entry,
	input  logic [15:0]         now_time,
	output logic                found,
	output logic [IDX_W-1:0]    best_idx,
	output logic [7:0]          best_pid
);

	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [7:0]       best_pid_q;
	logic [7:0]       best_prio_q;
	logic             take;

	// strictly greater, so on a tie the earlier slot stays
	assign take = ctl.take && (entry.arrival <= now_time) &&
	              (!found_q || (entry.prio > best_prio_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= idx;
			best_pid_q  <= entry.pid;
			best_prio_q <= entry.prio;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;
	assign best_pid = best_pid_q;

endmodule

### hdl/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Process table with preemptive highest-priority selection and gantt output.
//
//   channel  dir  handshake          payload
//   item     in   valid/ready        func, process_id, arrival_time,
//                                    burst_time, priority_level
//   result   out  valid/ready        status, now_time, running_*, finished_*,
//                                    segment_*, all_done
//
// A load passes through the load and emit states between acceptances. A tick
// reads the running entry, updates it when one runs, then scans the table one
// entry per cycle through the single read port of the entry memory, with read
// data and compare result both registered, before the finish and emit states.
// Reset clears all control state and the valid bits; no clearing pass.
// A stalled result holds the emit state and so blocks the next item's hand-over.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
	parameter int MAX_PROCESSES = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	pps_in_if.sink   item,
	pps_out_if.source result
);

	localparam int IDX_W = $clog2(MAX_PROCESSES);
	localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCESSES);

	pps_pkg::state_t state_q, state_d;

	// latched input transaction
	logic [7:0]  pid_in_q;
	logic [15:0] arr_in_q;
	logic [15:0] burst_in_q;
	logic [7:0]  prio_in_q;

	logic [MAX_PROCESSES-1:0] valid_q;
	logic [CNT_W-1:0]         loaded_q;
	logic [CNT_W-1:0]         live_q;
	logic [15:0]              time_q;
	logic [15:0]              seg_begin_q;
	logic [IDX_W-1:0]         run_idx_q;
	logic                     present_q;
	logic [7:0]               run_pid_q;
	logic                     ticking_q;
	logic                     done_q;
	logic [7:0]               fin_pid_q;

	logic [CNT_W-1:0]         scan_q;
	logic                     scan_valid_s1;
	logic                     scan_hit_s1;
	logic [IDX_W-1:0]         scan_idx_s1;

	pps_pkg::result_t res_q;
	pps_pkg::result_t out_q;
	logic             out_valid_q;

	// memory and selection wiring
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	pps_pkg::entry_t    mem_wdata;
	logic [IDX_W-1:0]   mem_raddr;
	pps_pkg::entry_t    mem_rdata;
	pps_pkg::scan_ctl_t scan_ctl;
	logic               sel_found;
	logic [IDX_W-1:0]   sel_idx;
	logic [7:0]         sel_pid;

	logic             load_ok;
	logic             load_first;
	logic [15:0]      rem_dec;
	logic             scan_issue;
	logic             scan_end;
	logic             change;
	logic             out_free;

	assign load_ok    = !ticking_q && (loaded_q < CNT_MAX);
	assign load_first = load_ok && (loaded_q == '0);
	assign rem_dec    = mem_rdata.remaining - 16'd1;
	assign scan_issue = (scan_q != loaded_q);
	assign scan_end   = !scan_issue && !scan_valid_s1;
	assign out_free   = !out_valid_q || result.ready;
	assign change     = done_q ||
	                    (present_q ? (!sel_found || (sel_idx != run_idx_q)) : sel_found);

	pps_entry_mem #(
		.DEPTH (MAX_PROCESSES),
		.AW    (IDX_W)
	) u_entry_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	pps_select #(
		.IDX_W (IDX_W)
	) u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (scan_ctl),
		.idx      (scan_idx_s1),
		.entry    (mem_rdata),
		.now_time (time_q),
		.found    (sel_found),
		.best_idx (sel_idx),
		.best_pid (sel_pid)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pps_pkg::ST_IDLE: begin
				if (item.valid) begin
					state_d = (item.func == pps_pkg::FUNC_TICK) ?
					          pps_pkg::ST_TICK_RD : pps_pkg::ST_LOAD;
				end
			end
			pps_pkg::ST_LOAD:    state_d = pps_pkg::ST_EMIT;
			pps_pkg::ST_TICK_RD: state_d = present_q ? pps_pkg::ST_UPDATE : pps_pkg::ST_SCAN;
			pps_pkg::ST_UPDATE:  state_d = pps_pkg::ST_SCAN;
			pps_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = pps_pkg::ST_FINISH;
				end
			end
			pps_pkg::ST_FINISH:  state_d = pps_pkg::ST_EMIT;
			pps_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = pps_pkg::ST_IDLE;
				end
			end
			default:             state_d = pps_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		item.ready     = 1'b0;
		mem_we         = 1'b0;
		mem_waddr      = run_idx_q;
		mem_wdata      = mem_rdata;
		mem_raddr      = scan_q[IDX_W-1:0];
		scan_ctl.clear = 1'b0;
		scan_ctl.take  = scan_valid_s1 && scan_hit_s1;
		case (state_q)
			pps_pkg::ST_IDLE: begin
				item.ready = 1'b1;
			end
			pps_pkg::ST_LOAD: begin
				mem_we              = load_ok;
				mem_waddr           = loaded_q[IDX_W-1:0];
				mem_wdata.pid       = pid_in_q;
				mem_wdata.arrival   = arr_in_q;
				mem_wdata.remaining = (burst_in_q == 16'd0) ? 16'd1 : burst_in_q;
				mem_wdata.prio      = prio_in_q;
			end
			pps_pkg::ST_TICK_RD: begin
				mem_raddr      = run_idx_q;
				scan_ctl.clear = 1'b1;
			end
			pps_pkg::ST_UPDATE: begin
				mem_we              = 1'b1;
				mem_wdata.remaining = rem_dec;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= pps_pkg::ST_IDLE;
			valid_q       <= '0;
			loaded_q      <= '0;
			live_q        <= '0;
			time_q        <= '0;
			seg_begin_q   <= '0;
			run_idx_q     <= '0;
			present_q     <= 1'b0;
			ticking_q     <= 1'b0;
			done_q        <= 1'b0;
			scan_q        <= '0;
			scan_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				pps_pkg::ST_LOAD: begin
					if (load_ok) begin
						valid_q[loaded_q[IDX_W-1:0]] <= 1'b1;
						loaded_q <= loaded_q + CNT_W'(1);
						live_q   <= live_q + CNT_W'(1);
					end
					if (load_first) begin
						time_q      <= arr_in_q;
						seg_begin_q <= arr_in_q;
						run_idx_q   <= '0;
						present_q   <= 1'b1;
					end
				end
				pps_pkg::ST_TICK_RD: begin
					time_q        <= time_q + 16'd1;
					ticking_q     <= 1'b1;
					done_q        <= 1'b0;
					scan_q        <= '0;
					scan_valid_s1 <= 1'b0;
				end
				pps_pkg::ST_UPDATE: begin
					if (rem_dec == 16'd0) begin
						valid_q[run_idx_q] <= 1'b0;
						live_q             <= live_q - CNT_W'(1);
						done_q             <= 1'b1;
					end
				end
				pps_pkg::ST_SCAN: begin
					scan_valid_s1 <= scan_issue;
					if (scan_issue) begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				pps_pkg::ST_FINISH: begin
					if (change) begin
						seg_begin_q <= time_q;
					end
					run_idx_q <= sel_found ? sel_idx : '0;
					present_q <= sel_found;
				end
				pps_pkg::ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			pps_pkg::ST_IDLE: begin
				if (item.valid) begin
					pid_in_q   <= item.process_id;
					arr_in_q   <= item.arrival_time;
					burst_in_q <= item.burst_time;
					prio_in_q  <= item.priority_level;
				end
			end
			pps_pkg::ST_LOAD: begin
				if (load_first) begin
					run_pid_q <= pid_in_q;
				end
				if (ticking_q) begin
					res_q.status <= pps_pkg::STATUS_REFUSED;
				end else if (!load_ok) begin
					res_q.status <= pps_pkg::STATUS_FULL;
				end else begin
					res_q.status <= pps_pkg::STATUS_OK;
				end
				res_q.now_time       <= load_first ? arr_in_q : time_q;
				res_q.running_valid  <= present_q || load_first;
				res_q.running_pid    <= load_first ? pid_in_q :
				                        (present_q ? run_pid_q : 8'd0);
				res_q.finished_valid <= 1'b0;
				res_q.finished_pid   <= 8'd0;
				res_q.segment_valid  <= 1'b0;
				res_q.segment_start  <= 16'd0;
				res_q.segment_end    <= 16'd0;
				res_q.segment_pid    <= 8'd0;
				res_q.all_done       <= (live_q == '0) && !load_ok;
			end
			pps_pkg::ST_UPDATE: begin
				fin_pid_q <= mem_rdata.pid;
			end
			pps_pkg::ST_SCAN: begin
				if (scan_issue) begin
					scan_idx_s1 <= scan_q[IDX_W-1:0];
					scan_hit_s1 <= valid_q[scan_q[IDX_W-1:0]];
				end
			end
			pps_pkg::ST_FINISH: begin
				if (sel_found) begin
					run_pid_q <= sel_pid;
				end
				res_q.status         <= pps_pkg::STATUS_OK;
				res_q.now_time       <= time_q;
				res_q.running_valid  <= sel_found;
				res_q.running_pid    <= sel_found ? sel_pid : 8'd0;
				res_q.finished_valid <= done_q;
				res_q.finished_pid   <= done_q ? fin_pid_q : 8'd0;
				res_q.segment_valid  <= change && present_q;
				res_q.segment_start  <= (change && present_q) ? seg_begin_q : 16'd0;
				res_q.segment_end    <= (change && present_q) ? time_q : 16'd0;
				res_q.segment_pid    <= (change && present_q) ? run_pid_q : 8'd0;
				res_q.all_done       <= (live_q == '0);
			end
			pps_pkg::ST_EMIT: begin
				if (out_free) begin
					out_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid          = out_valid_q;
	assign result.status         = out_q.status;
	assign result.now_time       = out_q.now_time;
	assign result.running_valid  = out_q.running_valid;
	assign result.running_pid    = out_q.running_pid;
	assign result.finished_valid = out_q.finished_valid;
	assign result.finished_pid   = out_q.finished_pid;
	assign result.segment_valid  = out_q.segment_valid;
	assign result.segment_start  = out_q.segment_start;
	assign result.segment_end    = out_q.segment_end;
	assign result.segment_pid    = out_q.segment_pid;
	assign result.all_done       = out_q.all_done;

endmodule

### hdl/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// Port-level checks on the scheduler's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [15:0] now_time,
	input logic        finished_valid,
	input logic        segment_valid,
	input logic [15:0] segment_end
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped while stalled");

	// a completing process always closes its segment
	a_fin_seg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished_valid |-> segment_valid)
		else $error("finished without a closed segment");

	a_seg_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && segment_valid |-> segment_end == now_time)
		else $error("segment end differs from clock");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != pps_pkg::STATUS_OK) |-> !finished_valid && !segment_valid)
		else $error("refused load reports tick activity");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.status         (result.status),
	.now_time       (result.now_time),
	.finished_valid (result.finished_valid),
	.segment_valid  (result.segment_valid),
	.segment_end    (result.segment_end)
);

### tb/pps_schedule_checker.sv
// ----------------------------------------------------------------------------
// pps_schedule_checker
// Watches both channels of the scheduler, keeps its own copy of the process
// table, predicts the result of every accepted item and compares each
// accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pps_schedule_checker #(
	parameter int MAX_PROCESSES = 16
) (
	input  logic clk,
	input  logic arst_n,
	pps_in_if    item,
	pps_out_if   result,
	output int   fail_count,
	output int   outstanding
);

	// Shadow process table and scheduler state
	logic        tbl_valid [MAX_PROCESSES];
	logic [7:0]  tbl_pid   [MAX_PROCESSES];
	logic [15:0] tbl_arr   [MAX_PROCESSES];
	logic [15:0] tbl_left  [MAX_PROCESSES];
	logic [7:0]  tbl_prio  [MAX_PROCESSES];
	int          n_loaded;
	logic [15:0] clock_now;
	int          run_slot;
	bit          run_on;
	logic [15:0] seg_from;
	bit          ticked;

	pps_pkg::result_t sched_outcomes_q [$];

	function automatic pps_pkg::result_t schedule_step(input logic func,
		input logic [7:0] pid, input logic [15:0] arr, input logic [15:0] burst,
		input logic [7:0] prio);
		pps_pkg::result_t r;
		int      prev;
		int      next;
		bit      prev_on;
		bit      done_now;
		bit      empty;
		r = '0;
		if (func == pps_pkg::FUNC_LOAD) begin
			if (ticked) begin
				r.status = pps_pkg::STATUS_REFUSED;
			end else if (n_loaded >= MAX_PROCESSES) begin
				r.status = pps_pkg::STATUS_FULL;
			end else begin
				tbl_valid[n_loaded] = 1'b1;
				tbl_pid[n_loaded]   = pid;
				tbl_arr[n_loaded]   = arr;
				tbl_left[n_loaded]  = (burst == 16'd0) ? 16'd1 : burst;
				tbl_prio[n_loaded]  = prio;
				// first load sets the clock and starts running at once
				if (n_loaded == 0) begin
					clock_now = arr;
					run_slot  = 0;
					run_on    = 1'b1;
					seg_from  = arr;
				end
				n_loaded++;
			end
		end else begin
			ticked    = 1'b1;
			clock_now = clock_now + 16'd1;
			prev      = run_slot;
			prev_on   = run_on;
			done_now  = 1'b0;
			if (prev_on) begin
				tbl_left[prev] = tbl_left[prev] - 16'd1;
				if (tbl_left[prev] == 16'd0) begin
					done_now           = 1'b1;
					tbl_valid[prev]    = 1'b0;
					r.finished_valid   = 1'b1;
					r.finished_pid     = tbl_pid[prev];
				end
			end
			// highest priority among arrived entries, lower slot wins a tie
			next = -1;
			for (int i = 0; i < MAX_PROCESSES; i++) begin
				if (tbl_valid[i] && tbl_arr[i] <= clock_now &&
				    (next < 0 || tbl_prio[i] > tbl_prio[next]))
					next = i;
			end
			if (done_now || (prev_on ? (next != prev) : (next >= 0))) begin
				if (prev_on) begin
					r.segment_valid = 1'b1;
					r.segment_start = seg_from;
					r.segment_end   = clock_now;
					r.segment_pid   = tbl_pid[prev];
				end
				seg_from = clock_now;
			end
			run_on   = (next >= 0);
			run_slot = (next >= 0) ? next : 0;
		end
		empty = 1'b1;
		for (int i = 0; i < MAX_PROCESSES; i++)
			if (tbl_valid[i])
				empty = 1'b0;
		r.now_time      = clock_now;
		r.running_valid = run_on;
		r.running_pid   = run_on ? tbl_pid[run_slot] : 8'd0;
		r.all_done      = empty;
		return r;
	endfunction

	function automatic bit field_ok(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pps_pkg::result_t want;
		int      bad;
		if (!arst_n) begin
			foreach (tbl_valid[i]) begin
				tbl_valid[i] = 1'b0;
				tbl_pid[i]   = '0;
				tbl_arr[i]   = '0;
				tbl_left[i]  = '0;
				tbl_prio[i]  = '0;
			end
			n_loaded    = 0;
			clock_now   = '0;
			run_slot    = 0;
			run_on      = 1'b0;
			seg_from    = '0;
			ticked      = 1'b0;
			sched_outcomes_q.delete();
			outstanding <= 0;
		end else begin
			if (item.valid && item.ready)
				sched_outcomes_q.push_back(schedule_step(item.func, item.process_id,
					item.arrival_time, item.burst_time, item.priority_level));
			if (result.valid && result.ready) begin
				if (sched_outcomes_q.size() == 0) begin
					$error("result transaction with no item outstanding");
					fail_count <= fail_count + 1;
				end else begin
					want = sched_outcomes_q.pop_front();
					bad  = 0;
					bad += !field_ok("status", 16'(want.status), 16'(result.status));
					bad += !field_ok("now_time", want.now_time, result.now_time);
					bad += !field_ok("running_valid", 16'(want.running_valid),
						16'(result.running_valid));
					bad += !field_ok("running_pid", 16'(want.running_pid),
						16'(result.running_pid));
					bad += !field_ok("finished_valid", 16'(want.finished_valid),
						16'(result.finished_valid));
					bad += !field_ok("finished_pid", 16'(want.finished_pid),
						16'(result.finished_pid));
					bad += !field_ok("segment_valid", 16'(want.segment_valid),
						16'(result.segment_valid));
					bad += !field_ok("segment_start", want.segment_start,
						result.segment_start);
					bad += !field_ok("segment_end", want.segment_end, result.segment_end);
					bad += !field_ok("segment_pid", 16'(want.segment_pid),
						16'(result.segment_pid));
					bad += !field_ok("all_done", 16'(want.all_done), 16'(result.all_done));
					if (bad != 0)
						fail_count <= fail_count + 1;
				end
			end
			outstanding <= sched_outcomes_q.size();
		end
	end

endmodule

### tb/preemptive_priority_scheduler_tb.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_tb
// Fills the process table close to the top of the clock range, overfills it,
// then ticks the schedule across the clock wrap and into idle time, with
// refused loads mixed in. Both channels stall at random; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_tb;

	localparam int TABLE_DEPTH  = 16;
	localparam int QUIET_LIMIT  = 2000;
	localparam int IDLE_PCT     = 16;
	localparam int DRAIN_CYCLES = 40;
	localparam int RAND_LOADS   = TABLE_DEPTH - 4;
	localparam int TICK_ITEMS   = 530;

	typedef struct packed {
		logic        func;
		logic [7:0]  pid;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
	} sched_item_t;

	logic clk;
	logic arst_n;
	bit   steady;
	int   fail_count;
	int   outstanding;
	int   quiet;

	pps_in_if  item ();
	pps_out_if result ();

	preemptive_priority_scheduler #(
		.MAX_PROCESSES(TABLE_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	pps_schedule_checker #(
		.MAX_PROCESSES(TABLE_DEPTH)
	) sched_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.result      (result),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("preemptive_priority_scheduler: mismatch");
				$finish;
			end
		end
	end

	function automatic sched_item_t random_payload();
		sched_item_t it;
		it.func    = 1'($urandom_range(0, 1));
		it.pid     = 8'($urandom_range(0, 255));
		it.arrival = 16'($urandom_range(0, 65535));
		it.burst   = 16'($urandom_range(0, 65535));
		it.prio    = 8'($urandom_range(0, 255));
		return it;
	endfunction

	function automatic sched_item_t load_item(input logic [7:0] pid,
		input logic [15:0] arrival, input logic [15:0] burst, input logic [7:0] prio);
		sched_item_t it;
		it.func    = pps_pkg::FUNC_LOAD;
		it.pid     = pid;
		it.arrival = arrival;
		it.burst   = burst;
		it.prio    = prio;
		return it;
	endfunction

	task automatic push_item(input sched_item_t it);
		item.valid          <= 1'b1;
		item.func           <= it.func;
		item.process_id     <= it.pid;
		item.arrival_time   <= it.arrival;
		item.burst_time     <= it.burst;
		item.priority_level <= it.prio;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			item.valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	endtask

	initial begin
		sched_item_t it;
		arst_n              <= 1'b0;
		steady              <= 1'b0;
		item.valid          <= 1'b0;
		item.func           <= pps_pkg::FUNC_LOAD;
		item.process_id     <= '0;
		item.arrival_time   <= '0;
		item.burst_time     <= '0;
		item.priority_level <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A tick before any load would lock the table empty for the whole run,
		// so every load comes first. Clock starts 32 ticks short of the wrap.
		push_item(load_item(8'hFF, 16'hFFE0, 16'h0000, 8'h00)); // zero burst
		push_item(load_item(8'h00, 16'hFFE4, 16'd2, 8'hFF));
		push_item(load_item(8'h01, 16'hFFE4, 16'd3, 8'hFF));    // tie, later slot
		push_item(load_item(8'h02, 16'hFFFF, 16'd1, 8'hFE));    // finishes on the wrap

		// arrivals below the start clock count as arrived until the wrap
		for (int i = 0; i < RAND_LOADS; i++) begin
			it         = random_payload();
			it.func    = pps_pkg::FUNC_LOAD;
			it.arrival = 16'($urandom_range(0, 360));
			it.burst   = 16'($urandom_range(0, 24));
			it.prio    = 8'($urandom_range(0, 253));
			push_item(it);
		end

		// table full
		push_item(load_item(8'hA5, 16'h0000, 16'hFFFF, 8'hFF));
		it      = random_payload();
		it.func = pps_pkg::FUNC_LOAD;
		push_item(it);

		for (int i = 0; i < TICK_ITEMS; i++) begin
			steady <= (i >= 200 && i < 330);
			it      = random_payload();
			// the odd load after ticking has begun, refused
			it.func = (i > 0 && $urandom_range(0, 99) < 6) ?
			          pps_pkg::FUNC_LOAD : pps_pkg::FUNC_TICK;
			push_item(it);
		end
		item.valid <= 1'b0;
		steady     <= 1'b0;

		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("preemptive_priority_scheduler: match");
		else
			$display("preemptive_priority_scheduler: mismatch");
		$finish;
	end

endmodule
